// ===== sv/wgd26_pkg.sv =====
// Shared types and constants for the Wiegand-26 transmitter.
`timescale 1ns / 1ps
`default_nettype none

package wgd26_pkg;

    // Item kinds on the cmd field
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_PULSE   = 2'd0;
    localparam logic [1:0] CFG_GAP     = 2'd1;
    localparam logic [1:0] CFG_HOLDOFF = 2'd2;

    // Register reset values
    localparam logic [15:0] PULSE_RST   = 16'd2;
    localparam logic [15:0] GAP_RST     = 16'd20;
    localparam logic [15:0] HOLDOFF_RST = 16'd3000;

    // Timing configuration as seen by the core
    typedef struct packed {
        logic [15:0] pulse_ticks;
        logic [15:0] gap_ticks;
        logic [15:0] holdoff_ticks;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic       line_zero;
        logic       line_one;
        logic       busy_res;
        logic       frame_waiting;
        logic [4:0] bits_sent;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/wgd26_cfg_regs.sv =====
// Timing configuration registers of the Wiegand-26 transmitter.
`timescale 1ns / 1ps
`default_nettype none

module wgd26_cfg_regs
    import wgd26_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    // Register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_ticks   <= PULSE_RST;
            cfg_reg.gap_ticks     <= GAP_RST;
            cfg_reg.holdoff_ticks <= HOLDOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PULSE:   cfg_reg.pulse_ticks   <= cfg_data;
                CFG_GAP:     cfg_reg.gap_ticks     <= cfg_data;
                CFG_HOLDOFF: cfg_reg.holdoff_ticks <= cfg_data;
                default:     ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/wgd26_core.sv =====
// Frame state and next-state logic of the Wiegand-26 transmitter.
`timescale 1ns / 1ps
`default_nettype none

module wgd26_core
    import wgd26_pkg::*;
#(
    parameter int DATA_BITS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic        cmd,
    input  wire logic [23:0] card_data,
    input  wire cfg_t        cfg,
    output res_t             res
);

    localparam int FL = DATA_BITS + 2;
    localparam int CW = $clog2(FL + 1);
    localparam int SW = $clog2(FL);
    localparam int LO = DATA_BITS - DATA_BITS / 2;
    localparam logic [CW-1:0] FL_C = CW'(FL);

    typedef enum logic [1:0] {PH_IDLE, PH_PULSE, PH_GAP} phase_t;

    logic [FL-1:0]        frame_reg, frame_next;
    logic [DATA_BITS-1:0] pend_reg, pend_next;
    logic                 pflag_reg, pflag_next;
    phase_t               phase_reg, phase_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [15:0]          timer_reg, timer_next;
    logic [15:0]          hold_reg, hold_next;

    logic [15:0]   pulse_len, gap_len, hold_dec, timer_dec;
    logic          even_par, odd_par;
    logic [CW-1:0] sh_full;
    logic          cur_bit;

    // Zero lengths behave as one tick
    assign pulse_len = (cfg.pulse_ticks == 16'd0) ? 16'd1 : cfg.pulse_ticks;
    assign gap_len   = (cfg.gap_ticks == 16'd0) ? 16'd1 : cfg.gap_ticks;
    assign hold_dec  = (hold_reg != 16'd0) ? hold_reg - 16'd1 : hold_reg;
    assign timer_dec = (timer_reg != 16'd0) ? timer_reg - 16'd1 : timer_reg;

    // Parity over the two halves of the pending data
    assign even_par = ^pend_reg[DATA_BITS-1:LO];
    assign odd_par  = ~(^pend_reg[LO-1:0]);

    // Next state for one load or tick
    always_comb
    begin
        frame_next = frame_reg;
        pend_next  = pend_reg;
        pflag_next = pflag_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        timer_next = timer_reg;
        hold_next  = hold_reg;
        if (cmd == CMD_LOAD)
        begin
            pend_next  = DATA_BITS'(card_data);
            pflag_next = 1'b1;
        end
        else
        begin
            hold_next = hold_dec;
            case (phase_reg)
                PH_PULSE, PH_GAP:
                begin
                    timer_next = timer_dec;
                    if (timer_dec == 16'd0)
                    begin
                        if (phase_reg == PH_PULSE)
                        begin
                            phase_next = PH_GAP;
                            timer_next = gap_len;
                        end
                        else if (cnt_reg >= FL_C)
                        begin
                            phase_next = PH_IDLE;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_PULSE;
                            timer_next = pulse_len;
                            cnt_next   = cnt_reg + CW'(1);
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (pflag_reg && hold_dec == 16'd0)
                    begin
                        frame_next = {even_par, pend_reg, odd_par};
                        pflag_next = 1'b0;
                        phase_next = PH_PULSE;
                        timer_next = pulse_len;
                        cnt_next   = CW'(1);
                        hold_next  = cfg.holdoff_ticks;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            pend_reg  <= '0;
            pflag_reg <= 1'b0;
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            timer_reg <= '0;
            hold_reg  <= '0;
        end
        else if (step)
        begin
            frame_reg <= frame_next;
            pend_reg  <= pend_next;
            pflag_reg <= pflag_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            timer_reg <= timer_next;
            hold_reg  <= hold_next;
        end
    end

    // Result from the state after the item
    assign sh_full = FL_C - cnt_next;
    assign cur_bit = frame_next[sh_full[SW-1:0]];

    always_comb
    begin
        res.line_zero     = 1'b1;
        res.line_one      = 1'b1;
        res.busy_res      = (phase_next == PH_PULSE) || (phase_next == PH_GAP);
        res.frame_waiting = pflag_next;
        res.bits_sent     = 5'd0;
        if (phase_next == PH_PULSE && cnt_next >= CW'(1) && cnt_next <= FL_C)
        begin
            if (cur_bit)
                res.line_one = 1'b0;
            else
                res.line_zero = 1'b0;
        end
        if (res.busy_res)
        begin
            if (32'(cnt_next) > 32'd31)
                res.bits_sent = 5'd31;
            else
                res.bits_sent = 5'(cnt_next);
        end
    end

endmodule

`default_nettype wire

// ===== sv/wiegand26_transmitter_top.sv =====
// Top level of the Wiegand-26 transmitter.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------------------
//  in       | input     | in_valid/in_stall   | cmd, card_data
//  out      | output    | out_valid/out_stall | line_zero, line_one, busy_res,
//           |           |                     | frame_waiting, bits_sent
//  cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// One item per cycle sustained while out is not stalled; a result reaches the outputs
// through the input register, which takes the item, and then the result register,
// which takes the state update.
// Reset clears the frame state, empties both stages and loads the timing defaults.
// A stalled result holds the result register; the input register still takes one
// more item, and in_stall rises only while both stages are full and out is stalled.
`timescale 1ns / 1ps
`default_nettype none

module wiegand26_transmitter_top
    import wgd26_pkg::*;
#(
    parameter int DATA_BITS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [23:0] card_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             line_zero,
    output logic             line_one,
    output logic             busy_res,
    output logic             frame_waiting,
    output logic [4:0]       bits_sent,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic        in_valid_reg;
    logic        cmd_reg;
    logic [23:0] data_reg;
    logic        out_valid_reg;
    res_t        res_reg;
    res_t        res_next;
    cfg_t        cfg;
    logic        advance;
    logic        in_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    wgd26_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wgd26_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .cmd       (cmd_reg),
        .card_data (data_reg),
        .cfg       (cfg),
        .res       (res_next)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_xfer)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg  <= cmd;
            data_reg <= card_data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign line_zero     = res_reg.line_zero;
    assign line_one      = res_reg.line_one;
    assign busy_res      = res_reg.busy_res;
    assign frame_waiting = res_reg.frame_waiting;
    assign bits_sent     = res_reg.bits_sent;

endmodule

`default_nettype wire

// ===== sv/wgd26_checker.sv =====
// Port-level checks for the Wiegand-26 transmitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wgd26_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       line_zero,
    input wire logic       line_one,
    input wire logic       busy_res,
    input wire logic       frame_waiting,
    input wire logic [4:0] bits_sent
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(line_zero) && $stable(line_one)
            && $stable(busy_res) && $stable(frame_waiting) && $stable(bits_sent))
        else $error("stalled result changed");

    // Never both data lines low
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_zero || line_one)
        else $error("both lines low");

    // Idle line shows no pulse and no bit count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> line_zero && line_one && bits_sent == 5'd0)
        else $error("activity while idle");

    // A running frame has started at least one bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && busy_res |-> bits_sent != 5'd0)
        else $error("busy with no bit started");

    // Input backpressure only comes from a stalled full output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

endmodule

bind wiegand26_transmitter_top wgd26_checker u_chk (.*);

`default_nettype wire
